// ===== design/aot_pkg.sv =====
// Shared types and constants for the station observation table.
// Used by every module of ap_observation_table_unit except aot_ram; no dependencies.
`default_nettype none
package aot_pkg;

  typedef struct packed {
    logic [47:0] station_address;
    logic [7:0]  radio_channel;
    logic        is_open;
    logic        fix_valid;
    logic [31:0] now_ms;
  } obs_req_t;

  typedef struct packed {
    logic [7:0]  slot;
    logic        was_new;
    logic        evicted;
    logic [23:0] hit_count;
    logic [8:0]  unique_count;
    logic [8:0]  open_total;
    logic [8:0]  fix_total;
    logic [31:0] channel_total;
    logic [31:0] observation_total;
  } obs_rsp_t;

  localparam int ADDR_W  = 48;
  localparam int TIME_W  = 32;
  localparam int HITS_W  = 24;
  localparam int CHAN_W  = 8;
  localparam int SUM_W   = 32;
  localparam int CNT_W   = 9;
  localparam int FLAG_OPEN_BIT = 0;
  localparam int FLAG_FIX_BIT  = 1;

  // One table entry as stored in memory.
  typedef struct packed {
    logic [47:0] addr;
    logic [31:0] last_seen;
    logic [31:0] first_seen;
    logic [23:0] hits;
    logic [7:0]  chan;
    logic [1:0]  flags;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture request
    logic scan_start; // reset scan index and best
    logic scan_step;  // consume one read word
    logic commit;     // write entry, update totals
    logic out_load;   // fill output register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last; // last read word consumed this cycle
    logic hit;       // address matched during scan
    logic empty;     // no occupied entries
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== design/aot_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module aot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== design/aot_datapath.sv =====
// Datapath: entry memory, scan index, match/oldest search and totals.
// Depends on aot_pkg and aot_ram.
`default_nettype none
module aot_datapath #(
  parameter int TABLE_ENTRIES = 256,
  parameter int CHANNEL_COUNT = 14
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire aot_pkg::obs_req_t req,
  input  wire aot_pkg::dp_cmd_t  cmd,
  output aot_pkg::dp_sts_t       sts,
  output aot_pkg::obs_rsp_t      rsp_r
);
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int OCC_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CH_IW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [OCC_W-1:0] FULL = OCC_W'(TABLE_ENTRIES);
  localparam logic [aot_pkg::HITS_W-1:0] HITS_MAX = '1;
  localparam logic [aot_pkg::SUM_W-1:0] SUM_MAX = '1;

  aot_pkg::obs_req_t req_r;
  logic [IDX_W-1:0]  rd_idx_r, cmp_idx_r, best_idx_r, hit_idx_r;
  logic [aot_pkg::TIME_W-1:0] best_time_r;
  logic              hit_r, best_vld_r;
  logic [OCC_W-1:0]  occ_r;
  logic [OCC_W-1:0]  open_r, fix_r;
  logic [aot_pkg::SUM_W-1:0] sums_r [CHANNEL_COUNT];
  logic [aot_pkg::SUM_W-1:0] obs_r;
  aot_pkg::entry_t   cur_r; // entry chosen for update

  logic [IDX_W-1:0]  ram_addr;
  logic              ram_we;
  aot_pkg::entry_t   ram_wdata, ram_rdata;

  logic [OCC_W-1:0]  scan_n;
  logic              match;

  aot_ram #(.WIDTH(aot_pkg::ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign scan_n = occ_r;
  assign match = ram_rdata.addr == req_r.station_address;
  assign sts.empty = occ_r == '0;
  assign sts.hit = hit_r;
  // Hit scan stops early on match; full-table eviction scan covers all entries.
  assign sts.scan_last = cmd.scan_step &&
      ((match && !hit_r) || ({1'b0, cmp_idx_r} == scan_n - OCC_W'(1)));

  // New entry contents, target slot and channel indices built from the current state.
  logic              fresh, evict;
  logic [IDX_W-1:0]  tgt;
  aot_pkg::entry_t   old_e, new_e;
  logic              old_cnt, new_cnt;
  logic [CH_IW-1:0]  old_ci, new_ci;
  logic [aot_pkg::HITS_W-1:0] base_hits;

  always_comb begin
    fresh = !hit_r;
    evict = fresh && occ_r == FULL;
    tgt = hit_r ? hit_idx_r : (evict ? best_idx_r : occ_r[IDX_W-1:0]);
    old_e = cur_r;
    base_hits = fresh ? '0 : old_e.hits;
    new_e.addr = req_r.station_address;
    new_e.chan = req_r.radio_channel;
    new_e.last_seen = req_r.now_ms;
    new_e.first_seen = fresh ? req_r.now_ms : old_e.first_seen;
    new_e.hits = (base_hits < HITS_MAX) ? base_hits + 1'b1 : base_hits;
    new_e.flags[aot_pkg::FLAG_OPEN_BIT] = req_r.is_open;
    new_e.flags[aot_pkg::FLAG_FIX_BIT] = req_r.fix_valid ||
        (!fresh && old_e.flags[aot_pkg::FLAG_FIX_BIT]);
    old_cnt = (hit_r || evict) && old_e.chan >= 8'd1 &&
        {24'd0, old_e.chan} <= 32'(CHANNEL_COUNT);
    new_cnt = req_r.radio_channel >= 8'd1 &&
        {24'd0, req_r.radio_channel} <= 32'(CHANNEL_COUNT);
    old_ci = CH_IW'(old_e.chan - 8'd1);
    new_ci = CH_IW'(req_r.radio_channel - 8'd1);
  end

  assign ram_we = cmd.commit;
  assign ram_wdata = new_e;
  // Entry 0 is read until the scan steps; the scan index runs one ahead.
  assign ram_addr = cmd.commit ? tgt : (cmd.scan_step ? rd_idx_r : '0);

  logic [aot_pkg::SUM_W-1:0] rem_v, add_v, new_sum;
  always_comb begin
    rem_v = sums_r[old_ci];
    if (old_cnt) begin
      rem_v = (sums_r[old_ci] >= 32'(old_e.hits)) ? sums_r[old_ci] - 32'(old_e.hits) : '0;
    end
    add_v = (old_cnt && old_ci == new_ci) ? rem_v : sums_r[new_ci];
    new_sum = (SUM_MAX - add_v < 32'(new_e.hits)) ? SUM_MAX : add_v + 32'(new_e.hits);
  end

  logic [OCC_W-1:0] open_nxt, fix_nxt, occ_nxt;
  logic [aot_pkg::SUM_W-1:0] obs_nxt;
  always_comb begin
    open_nxt = open_r;
    fix_nxt = fix_r;
    if ((hit_r || evict) && old_e.flags[aot_pkg::FLAG_OPEN_BIT] && open_nxt != '0)
      open_nxt = open_nxt - 1'b1;
    if ((hit_r || evict) && old_e.flags[aot_pkg::FLAG_FIX_BIT] && fix_nxt != '0)
      fix_nxt = fix_nxt - 1'b1;
    if (new_e.flags[aot_pkg::FLAG_OPEN_BIT]) open_nxt = open_nxt + 1'b1;
    if (new_e.flags[aot_pkg::FLAG_FIX_BIT]) fix_nxt = fix_nxt + 1'b1;
    occ_nxt = (fresh && !evict) ? occ_r + 1'b1 : occ_r;
    obs_nxt = (obs_r < SUM_MAX) ? obs_r + 1'b1 : obs_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      open_r <= '0;
      fix_r <= '0;
      obs_r <= '0;
      hit_r <= 1'b0;
      best_vld_r <= 1'b0;
      for (int k = 0; k < CHANNEL_COUNT; k++) sums_r[k] <= '0;
    end else begin
      if (cmd.load) req_r <= req;
      if (cmd.scan_start) begin
        rd_idx_r <= IDX_W'(1);
        cmp_idx_r <= '0;
        hit_r <= 1'b0;
        best_vld_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        rd_idx_r <= rd_idx_r + 1'b1;
        cmp_idx_r <= cmp_idx_r + 1'b1;
        if (!hit_r && match) begin
          hit_r <= 1'b1;
          hit_idx_r <= cmp_idx_r;
          cur_r <= ram_rdata;
        end else if (!hit_r && (!best_vld_r || ram_rdata.last_seen < best_time_r)) begin
          best_vld_r <= 1'b1;
          best_time_r <= ram_rdata.last_seen;
          best_idx_r <= cmp_idx_r;
          if (occ_r == FULL) cur_r <= ram_rdata;
        end
      end
      if (cmd.commit) begin
        occ_r <= occ_nxt;
        open_r <= open_nxt;
        fix_r <= fix_nxt;
        obs_r <= obs_nxt;
        if (old_cnt && !(new_cnt && old_ci == new_ci)) sums_r[old_ci] <= rem_v;
        if (new_cnt) sums_r[new_ci] <= new_sum;
      end
      if (cmd.out_load) begin
        rsp_r.slot <= 8'(tgt);
        rsp_r.was_new <= fresh;
        rsp_r.evicted <= evict;
        rsp_r.hit_count <= new_e.hits;
        rsp_r.unique_count <= aot_pkg::CNT_W'(occ_nxt);
        rsp_r.open_total <= aot_pkg::CNT_W'(open_nxt);
        rsp_r.fix_total <= aot_pkg::CNT_W'(fix_nxt);
        rsp_r.channel_total <= new_cnt ? new_sum : '0;
        rsp_r.observation_total <= obs_nxt;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/aot_ctrl.sv =====
// Controller FSM for the observation table: handshake and scan sequencing.
// Depends on aot_pkg.
`default_nettype none
module aot_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output aot_pkg::dp_cmd_t      cmd,
  input  wire aot_pkg::dp_sts_t sts
);
  typedef enum logic [2:0] {S_IDLE, S_PRIME, S_SCAN, S_COMMIT} state_t;
  state_t state_r;
  logic   out_valid_r;

  assign out_valid = out_valid_r;
  assign in_stall = !(state_r == S_IDLE && !out_valid_r);

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && !in_stall;
    cmd.scan_start = state_r == S_IDLE;
    cmd.scan_step = state_r == S_SCAN;
    cmd.commit = state_r == S_COMMIT;
    cmd.out_load = cmd.commit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cmd.load) state_r <= sts.empty ? S_COMMIT : S_PRIME;
        end
        S_PRIME: state_r <= S_SCAN;
        S_SCAN: begin
          if (sts.scan_last) state_r <= S_COMMIT;
        end
        S_COMMIT: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/ap_observation_table_unit.sv =====
// Top level of the station observation table.
// Depends on aot_pkg, aot_ctrl, aot_datapath, aot_ram.
//
// Channel  Handshake            Payload
// in_      in_valid/in_stall    aot_pkg::obs_req_t
// out_     out_valid/out_stall  aot_pkg::obs_rsp_t
//
// Accept to result: prime the RAM, read N entries (N = occupied entries, fewer
// on an early hit), one RAM read per entry through the single port, then a commit.
// An empty table skips priming and scan and goes straight to the commit. A full
// table miss reads all TABLE_ENTRIES entries. No clearing pass.
// A new request is taken only once the previous result has left.
`default_nettype none
module ap_observation_table_unit #(
  parameter int TABLE_ENTRIES = 256,
  parameter int CHANNEL_COUNT = 14
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire aot_pkg::obs_req_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output aot_pkg::obs_rsp_t      out_data
);
  aot_pkg::dp_cmd_t cmd;
  aot_pkg::dp_sts_t sts;

  aot_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  aot_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .CHANNEL_COUNT(CHANNEL_COUNT)) u_dp (
    .clk(clk), .rst_n(rst_n), .req(in_data), .cmd(cmd), .sts(sts), .rsp_r(out_data)
  );
endmodule
`default_nettype wire

// ===== design/aot_checker.sv =====
// Port-level checker for ap_observation_table_unit, bound to the top level.
// Depends on aot_pkg.
`default_nettype none
module aot_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire aot_pkg::obs_rsp_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");

  a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken with result pending");

  a_take_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken before result");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.evicted |-> out_data.was_new)
    else $error("eviction without new entry");
endmodule

bind ap_observation_table_unit aot_checker u_aot_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
